// ===== sv/sample_playback_resampler_assert.svh =====
// -----------------------------------------------------------------------------
// sample_playback_resampler_assert
// assertion macros shared by the resampler modules; they expect clk and rst_n
// in scope
// -----------------------------------------------------------------------------
`ifndef SAMPLE_PLAYBACK_RESAMPLER_ASSERT_SVH
`define SAMPLE_PLAYBACK_RESAMPLER_ASSERT_SVH

// same-cycle implication
`define SPR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spr: same-cycle check failed");

// next-cycle implication
`define SPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spr: next-cycle check failed");

`endif

// ===== sv/spr_pkg.sv =====
// -----------------------------------------------------------------------------
// spr_pkg
// types and constants of the sample playback resampler
// -----------------------------------------------------------------------------
package spr_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned POS_W      = 14;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned STEP_W     = 20;
  localparam int unsigned WADDR_W    = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // phase step after reset is one source frame per output frame
  localparam logic [STEP_W-1:0] STEP_RESET = 20'h10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd4;

  // item modes
  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_FRAME   = 2'd1,
    MODE_RESTART = 2'd2
  } spr_mode_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [WADDR_W-1:0]         write_address;
    logic signed [SAMPLE_W-1:0] write_data;
  } spr_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       wrapped;
    logic                       ended;
  } spr_out_t;

  typedef struct packed {
    logic              play_enable;
    logic              stereo_mode;
    logic              loop_enable;
    logic [STEP_W-1:0] phase_step;
    logic [POS_W-1:0]  frame_count;
  } spr_cfg_t;

  // per-frame control carried from the phase unit to the result stage
  typedef struct packed {
    logic play;
    logic stereo;
    logic wrapped;
    logic ended;
  } spr_frame_t;

endpackage

// ===== sv/spr_sample_mem.sv =====
// -----------------------------------------------------------------------------
// spr_sample_mem
// sample word memory, one write port and two registered read ports
// -----------------------------------------------------------------------------
module spr_sample_mem #(
  parameter int unsigned SAMPLE_WORDS = 8192,
  localparam int unsigned AW = $clog2(SAMPLE_WORDS)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [spr_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr_a,
  input  logic [AW-1:0]                rd_addr_b,
  output logic [spr_pkg::SAMPLE_W-1:0] rd_data_a,
  output logic [spr_pkg::SAMPLE_W-1:0] rd_data_b
);

  logic [spr_pkg::SAMPLE_W-1:0] mem [SAMPLE_WORDS];
  logic [spr_pkg::SAMPLE_W-1:0] rd_a_r;
  logic [spr_pkg::SAMPLE_W-1:0] rd_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, data held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== sv/spr_phase.sv =====
// -----------------------------------------------------------------------------
// spr_phase
// phase accumulator, end-of-sample handling and read address generation
// -----------------------------------------------------------------------------
`include "sample_playback_resampler_assert.svh"

module spr_phase #(
  parameter int unsigned SAMPLE_WORDS = 8192,
  localparam int unsigned AW = $clog2(SAMPLE_WORDS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spr_pkg::spr_cfg_t   cfg,
  input  logic                frame_go,
  input  logic                restart_go,
  output spr_pkg::spr_frame_t frame,
  output logic [AW-1:0]       rd_addr_a,
  output logic [AW-1:0]       rd_addr_b
);

  localparam int unsigned SUM_W = spr_pkg::STEP_W + 1;
  localparam int unsigned CARRY_W = SUM_W - spr_pkg::FRAC_W;
  localparam int unsigned LIN_W = spr_pkg::POS_W + 1;
  localparam int unsigned EW = (AW > LIN_W) ? AW : LIN_W;

  logic [spr_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [spr_pkg::FRAC_W-1:0] frac_r, frac_nxt;
  logic                       stopped_r, stopped_nxt;

  logic [SUM_W-1:0]          sum;
  logic [LIN_W-1:0]          pos_adv;
  logic                      at_end;
  logic                      advance;
  logic [spr_pkg::POS_W-1:0] play_pos;
  logic [LIN_W-1:0]          lin_a;
  logic [LIN_W-1:0]          lin_b;
  logic [EW-1:0]             ext_a;
  logic [EW-1:0]             ext_b;

  // fraction add, carry into position, end compare
  assign sum = SUM_W'(frac_r) + SUM_W'(cfg.phase_step);
  assign pos_adv = LIN_W'(pos_r) + LIN_W'(sum[SUM_W-1 -: CARRY_W]);
  assign at_end = (pos_adv >= LIN_W'(cfg.frame_count));
  assign play_pos = at_end ? '0 : pos_adv[spr_pkg::POS_W-1:0];

  // frame decision
  always_comb begin
    frame = '0;
    frame.stereo = cfg.stereo_mode;
    advance = 1'b0;
    priority if (!cfg.play_enable) begin
      frame.ended = stopped_r;
    end else if (stopped_r) begin
      frame.ended = 1'b1;
    end else if (at_end && !cfg.loop_enable) begin
      frame.ended = 1'b1;
    end else begin
      frame.play = 1'b1;
      frame.wrapped = at_end;
      advance = 1'b1;
    end
  end

  // state next value
  always_comb begin
    pos_nxt = pos_r;
    frac_nxt = frac_r;
    stopped_nxt = stopped_r;
    priority if (restart_go) begin
      pos_nxt = '0;
      frac_nxt = '0;
      stopped_nxt = 1'b0;
    end else if (frame_go) begin
      if (advance) begin
        pos_nxt = play_pos;
        frac_nxt = sum[spr_pkg::FRAC_W-1:0];
      end else if (cfg.play_enable && !stopped_r) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      frac_r <= '0;
      stopped_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      frac_r <= frac_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // word addresses, taken modulo the memory depth
  assign lin_a = cfg.stereo_mode ? {play_pos, 1'b0} : {1'b0, play_pos};
  assign lin_b = {play_pos, 1'b1};
  assign ext_a = EW'(lin_a);
  assign ext_b = EW'(lin_b);
  assign rd_addr_a = ext_a[AW-1:0];
  assign rd_addr_b = ext_b[AW-1:0];

  `SPR_ASSERT_NEXT(a_restart_clears, restart_go, pos_r == '0 && frac_r == '0 && !stopped_r)
  `SPR_ASSERT_NEXT(a_idle_holds_pos, !frame_go && !restart_go, $stable(pos_r) && $stable(frac_r))

endmodule

// ===== sv/sample_playback_resampler.sv =====
// throughput: one item per cycle while no frame request is held by out_ready,
// set by the single-pass phase unit and the two read ports of the sample
// memory, both used in the same cycle for stereo
// reset: synchronous active-low rst_n clears pipeline valids, position, fraction,
// stopped flag and loads config defaults; sample memory is not cleared
// -----------------------------------------------------------------------------
// sample_playback_resampler
// drop-sample playback of 16-bit pcm from a sample memory, mono or stereo,
// with a 4.16 phase step and optional looping
// -----------------------------------------------------------------------------
`include "sample_playback_resampler_assert.svh"

module sample_playback_resampler #(
  parameter int unsigned SAMPLE_WORDS = 8192
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  spr_pkg::spr_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output spr_pkg::spr_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned AW = $clog2(SAMPLE_WORDS);
  localparam int unsigned WEW = (AW > spr_pkg::WADDR_W) ? AW : spr_pkg::WADDR_W;

  spr_pkg::spr_cfg_t   cfg_r;
  logic                s0_valid_r;
  spr_pkg::spr_in_t    s0_item_r;
  logic                s1_valid_r;
  spr_pkg::spr_frame_t s1_frame_r;

  logic                s1_can;
  logic                s0_is_frame;
  logic                s0_go;
  logic                frame_go;
  logic                restart_go;
  logic                wr_go;
  spr_pkg::spr_frame_t frame;
  logic [AW-1:0]       rd_addr_a;
  logic [AW-1:0]       rd_addr_b;
  logic [WEW-1:0]      wr_addr_ext;
  logic [spr_pkg::SAMPLE_W-1:0] rd_data_a;
  logic [spr_pkg::SAMPLE_W-1:0] rd_data_b;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.play_enable <= 1'b0;
      cfg_r.stereo_mode <= 1'b0;
      cfg_r.loop_enable <= 1'b0;
      cfg_r.phase_step <= spr_pkg::STEP_RESET;
      cfg_r.frame_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spr_pkg::CFG_PLAY_ENABLE: cfg_r.play_enable <= cfg_wdata[0];
        spr_pkg::CFG_STEREO_MODE: cfg_r.stereo_mode <= cfg_wdata[0];
        spr_pkg::CFG_LOOP_ENABLE: cfg_r.loop_enable <= cfg_wdata[0];
        spr_pkg::CFG_PHASE_STEP:  cfg_r.phase_step <= cfg_wdata[spr_pkg::STEP_W-1:0];
        spr_pkg::CFG_FRAME_COUNT: cfg_r.frame_count <= cfg_wdata[spr_pkg::POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage control: only frame requests need room in the result stage
  assign s1_can = !s1_valid_r || out_ready;
  assign s0_is_frame = (s0_item_r.mode == spr_pkg::MODE_FRAME);
  assign s0_go = s0_valid_r && (!s0_is_frame || s1_can);
  assign frame_go = s0_go && s0_is_frame;
  assign restart_go = s0_go && (s0_item_r.mode == spr_pkg::MODE_RESTART);
  assign wr_go = s0_go && (s0_item_r.mode == spr_pkg::MODE_WRITE);
  assign in_ready = !s0_valid_r || s0_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_item_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_can) begin
      s1_valid_r <= frame_go;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_go) begin
      s1_frame_r <= frame;
    end
  end

  spr_phase #(
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .frame_go   (frame_go),
    .restart_go (restart_go),
    .frame      (frame),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b)
  );

  assign wr_addr_ext = WEW'(s0_item_r.write_address);

  spr_sample_mem #(
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_go),
    .wr_addr   (wr_addr_ext[AW-1:0]),
    .wr_data   (s0_item_r.write_data),
    .rd_en     (frame_go),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // result formatting: silence when not playing, mono duplicates the word
  always_comb begin
    out_data = '0;
    out_data.wrapped = s1_frame_r.wrapped;
    out_data.ended = s1_frame_r.ended;
    if (s1_frame_r.play) begin
      out_data.left_sample = rd_data_a;
      out_data.right_sample = s1_frame_r.stereo ? rd_data_b : rd_data_a;
    end
  end

  assign out_valid = s1_valid_r;

  `SPR_ASSERT_IMPLY(a_no_wrap_and_end, out_valid, !(out_data.wrapped && out_data.ended))
  `SPR_ASSERT_IMPLY(a_frame_needs_room, frame_go, s1_can && s0_valid_r)
  `SPR_ASSERT_IMPLY(a_ready_low_busy, !in_ready, s0_valid_r && s0_is_frame && !s1_can)

endmodule
